// File: rtl/core/tskt_pkg.sv
`timescale 1ns / 1ps
package tskt_pkg;
    localparam int ENTRIES_DEF = 64;
    localparam int KEY_W = 32;
    localparam int PLO_W = 64;
    localparam int PHI_W = 24;
    localparam int REC_W = KEY_W + PLO_W + PHI_W;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SORT   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FOUND = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_LEAF,
        S_BUILD_RD,
        S_BUILD_WR,
        S_ROOT_RD,
        S_ROOT_WR,
        S_PATH_RD,
        S_PATH_WR,
        S_PERM_RD,
        S_PERM_WR,
        S_COPY_RD,
        S_COPY_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [KEY_W-1:0] wkey;
        logic [PLO_W-1:0] wplo;
        logic [PHI_W-1:0] wphi;
    } t_rec_wr;
endpackage

// File: rtl/core/tskt_rec_mem.sv
`timescale 1ns / 1ps
module tskt_rec_mem #(
    parameter int ENTRIES = tskt_pkg::ENTRIES_DEF,
    parameter int AW = $clog2(ENTRIES)
) (
    input  logic                     i_clk,
    input  logic [AW-1:0]            i_waddr,
    input  tskt_pkg::t_rec_wr        i_wr,
    input  logic [AW-1:0]            i_raddr,
    output logic [tskt_pkg::REC_W-1:0] o_rdata
);
    logic [tskt_pkg::REC_W-1:0] mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_waddr] <= {i_wr.wkey, i_wr.wplo, i_wr.wphi};
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// File: rtl/core/tskt_aux_mem.sv
`timescale 1ns / 1ps
module tskt_aux_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 6,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end
endmodule

// File: rtl/core/tournament_sorted_key_table.sv
`timescale 1ns / 1ps
// Sort timing is set by the one-read-per-cycle record memory and the winner-tree walk.
// One word in flight at a time: busy stays high until its result strobe.
// Synchronous active-low reset clears the count and control; memories are not
// cleared. The receiver cannot stall the result.
module tournament_sorted_key_table #(
    parameter int ENTRIES = tskt_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic signed [tskt_pkg::KEY_W-1:0] i_key_value,
    input  logic [tskt_pkg::PLO_W-1:0]    i_payload_low,
    input  logic [tskt_pkg::PHI_W-1:0]    i_payload_high,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic signed [tskt_pkg::KEY_W-1:0] o_found_key,
    output logic [tskt_pkg::PLO_W-1:0]    o_found_payload_low,
    output logic [tskt_pkg::PHI_W-1:0]    o_found_payload_high,
    output logic [6:0]                    o_record_count
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int TW = AW + 1;
    localparam int TDEPTH = 2 ** TW;
    localparam int KW = tskt_pkg::KEY_W;
    localparam int PLW = tskt_pkg::PLO_W;
    localparam int PHW = tskt_pkg::PHI_W;

    tskt_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [KW-1:0] r_key;
    logic [CW-1:0] r_low, n_low, r_high, n_high;
    logic [AW-1:0] r_mid;
    logic [TW-1:0] r_leaves, n_leaves;
    logic [TW-1:0] r_node, n_node;
    logic [CW-1:0] r_j, n_j;
    logic [AW-1:0] r_wa, r_wb, n_wa, n_wb;
    logic [1:0]    r_sub, n_sub;
    logic [KW-1:0] r_ka;
    logic          r_valid, n_valid;
    logic [1:0]    r_status, n_status;
    logic [KW-1:0] r_fkey, n_fkey;
    logic [PLW-1:0] r_fplo, n_fplo;
    logic [PHW-1:0] r_fphi, n_fphi;

    tskt_pkg::t_rec_wr rec_wr, tmp_wr;
    logic [AW-1:0] rec_waddr, rec_raddr, tmp_waddr, tmp_raddr;
    logic [tskt_pkg::REC_W-1:0] rec_rdata, tmp_rdata;
    logic tree_we, scr_we;
    logic [TW-1:0] tree_waddr, tree_ra, tree_rb;
    logic [AW-1:0] tree_wdata, tree_da, tree_db, scr_wdata, scr_rdata, scr_unused;
    logic [AW-1:0] scr_waddr, scr_raddr;
    logic          cons_we, cons_wdata, cons_da, cons_db;
    logic [AW-1:0] cons_waddr;

    logic [KW-1:0] rd_key;
    logic [AW-1:0] win;
    logic [CW-1:0] mid_c;

    assign rd_key = rec_rdata[tskt_pkg::REC_W-1 -: KW];

    tskt_rec_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_rec (
        .i_clk(i_clk), .i_waddr(rec_waddr), .i_wr(rec_wr),
        .i_raddr(rec_raddr), .o_rdata(rec_rdata));
    tskt_rec_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_tmp (
        .i_clk(i_clk), .i_waddr(tmp_waddr), .i_wr(tmp_wr),
        .i_raddr(tmp_raddr), .o_rdata(tmp_rdata));
    tskt_aux_mem #(.DEPTH(TDEPTH), .WIDTH(AW), .AW(TW)) u_tree (
        .i_clk(i_clk), .i_we(tree_we), .i_waddr(tree_waddr), .i_wdata(tree_wdata),
        .i_raddr_a(tree_ra), .i_raddr_b(tree_rb),
        .o_rdata_a(tree_da), .o_rdata_b(tree_db));
    tskt_aux_mem #(.DEPTH(ENTRIES), .WIDTH(AW), .AW(AW)) u_scr (
        .i_clk(i_clk), .i_we(scr_we), .i_waddr(scr_waddr), .i_wdata(scr_wdata),
        .i_raddr_a(scr_raddr), .i_raddr_b(scr_raddr),
        .o_rdata_a(scr_rdata), .o_rdata_b(scr_unused));
    // Consumed flags, cleared while the leaves are loaded.
    tskt_aux_mem #(.DEPTH(ENTRIES), .WIDTH(1), .AW(AW)) u_cons (
        .i_clk(i_clk), .i_we(cons_we), .i_waddr(cons_waddr), .i_wdata(cons_wdata),
        .i_raddr_a(r_wa), .i_raddr_b(r_wb),
        .o_rdata_a(cons_da), .o_rdata_b(cons_db));

    // Winner choice; flags and second key arrive in the decide step, first key in r_ka.
    always_comb begin
        if (cons_da != cons_db) begin
            win = cons_da ? r_wb : r_wa;
        end else if (cons_da) begin
            win = r_wa;
        end else begin
            win = ($signed(r_ka) <= $signed(rd_key)) ? r_wa : r_wb;
        end
    end

    assign mid_c = r_low + ((r_high - r_low - CW'(1)) >> 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tskt_pkg::S_IDLE: begin
                if (start) begin
                    unique case (tskt_pkg::t_op'(i_opcode))
                        tskt_pkg::OP_SEARCH: n_state = tskt_pkg::S_SRCH_RD;
                        tskt_pkg::OP_SORT: n_state = (r_count < CW'(2)) ?
                            tskt_pkg::S_DONE : tskt_pkg::S_LEAF;
                        default: n_state = tskt_pkg::S_DONE;
                    endcase
                end
            end
            tskt_pkg::S_SRCH_RD: n_state = (r_low < r_high) ?
                tskt_pkg::S_SRCH_CMP : tskt_pkg::S_DONE;
            tskt_pkg::S_SRCH_CMP: n_state = (rd_key == r_key) ?
                tskt_pkg::S_DONE : tskt_pkg::S_SRCH_RD;
            tskt_pkg::S_LEAF: if (r_node == r_leaves - TW'(1))
                n_state = (r_leaves == TW'(1)) ? tskt_pkg::S_ROOT_RD : tskt_pkg::S_BUILD_RD;
            tskt_pkg::S_BUILD_RD: n_state = tskt_pkg::S_BUILD_WR;
            tskt_pkg::S_BUILD_WR: if (r_sub == 2'd2)
                n_state = (r_node == TW'(1)) ? tskt_pkg::S_ROOT_RD : tskt_pkg::S_BUILD_RD;
            tskt_pkg::S_ROOT_RD: n_state = tskt_pkg::S_ROOT_WR;
            tskt_pkg::S_ROOT_WR: n_state = tskt_pkg::S_PATH_RD;
            tskt_pkg::S_PATH_RD: n_state = (r_node == '0) ?
                ((r_j == r_count) ? tskt_pkg::S_PERM_RD : tskt_pkg::S_ROOT_RD) :
                tskt_pkg::S_PATH_WR;
            tskt_pkg::S_PATH_WR: if (r_sub == 2'd2) n_state = tskt_pkg::S_PATH_RD;
            tskt_pkg::S_PERM_RD: n_state = tskt_pkg::S_PERM_WR;
            tskt_pkg::S_PERM_WR: if (r_sub == 2'd1)
                n_state = (r_j == r_count - CW'(1)) ? tskt_pkg::S_COPY_RD : tskt_pkg::S_PERM_RD;
            tskt_pkg::S_COPY_RD: n_state = tskt_pkg::S_COPY_WR;
            tskt_pkg::S_COPY_WR: n_state = (r_j == r_count - CW'(1)) ?
                tskt_pkg::S_DONE : tskt_pkg::S_COPY_RD;
            tskt_pkg::S_DONE: n_state = tskt_pkg::S_IDLE;
            default: n_state = tskt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count; n_low = r_low; n_high = r_high; n_leaves = r_leaves;
        n_node = r_node; n_j = r_j; n_wa = r_wa; n_wb = r_wb; n_sub = r_sub;
        n_valid = 1'b0; n_status = r_status;
        n_fkey = r_fkey; n_fplo = r_fplo; n_fphi = r_fphi;
        rec_wr = '0; rec_waddr = '0; rec_raddr = '0;
        tmp_wr = '0; tmp_waddr = '0; tmp_raddr = '0;
        tree_we = 1'b0; tree_waddr = '0; tree_wdata = '0; tree_ra = '0; tree_rb = '0;
        scr_we = 1'b0; scr_waddr = '0; scr_wdata = '0; scr_raddr = '0;
        cons_we = 1'b0; cons_waddr = '0; cons_wdata = 1'b0;
        unique case (r_state)
            tskt_pkg::S_IDLE: begin
                if (start) begin
                    n_status = tskt_pkg::ST_DONE;
                    n_fkey = '0; n_fplo = '0; n_fphi = '0;
                    n_low = '0; n_high = r_count;
                    n_node = '0; n_j = '0; n_sub = '0;
                    n_leaves = TW'(1);
                    for (int k = 1; k <= AW; k++) begin
                        if ((TW'(1) << (k - 1)) < TW'(r_count)) n_leaves = TW'(1) << k;
                    end
                    unique case (tskt_pkg::t_op'(i_opcode))
                        tskt_pkg::OP_CLEAR: n_count = '0;
                        tskt_pkg::OP_APPEND: begin
                            if (r_count >= CW'(ENTRIES)) begin
                                n_status = tskt_pkg::ST_FULL;
                            end else begin
                                rec_wr = '{1'b1, i_key_value, i_payload_low, i_payload_high};
                                rec_waddr = r_count[AW-1:0];
                                n_count = r_count + CW'(1);
                            end
                        end
                        tskt_pkg::OP_SEARCH: n_status = tskt_pkg::ST_MISS;
                        default: ;
                    endcase
                end
            end
            tskt_pkg::S_SRCH_RD: rec_raddr = mid_c[AW-1:0];
            tskt_pkg::S_SRCH_CMP: begin
                if (rd_key == r_key) begin
                    n_status = tskt_pkg::ST_FOUND;
                    n_fkey = rd_key;
                    n_fplo = rec_rdata[PHW +: PLW];
                    n_fphi = rec_rdata[PHW-1:0];
                end else if ($signed(rd_key) < $signed(r_key)) begin
                    n_low = CW'(r_mid) + CW'(1);
                end else begin
                    n_high = CW'(r_mid);
                end
            end
            tskt_pkg::S_LEAF: begin
                tree_we = 1'b1;
                tree_waddr = r_leaves + r_node;
                tree_wdata = (r_node < TW'(r_count)) ? r_node[AW-1:0] :
                    AW'(r_count - CW'(1));
                if (r_node < TW'(r_count)) begin
                    cons_we = 1'b1;
                    cons_waddr = r_node[AW-1:0];
                end
                n_node = r_node + TW'(1);
                if (r_node == r_leaves - TW'(1)) n_node = r_leaves - TW'(1);
            end
            tskt_pkg::S_BUILD_RD, tskt_pkg::S_PATH_RD: begin
                tree_ra = TW'(r_node << 1);
                tree_rb = TW'((r_node << 1) | TW'(1));
                n_sub = '0;
            end
            tskt_pkg::S_BUILD_WR, tskt_pkg::S_PATH_WR: begin
                // sub 0: fetch key a; sub 1: fetch key b; sub 2: decide
                if (r_sub == 2'd0) begin
                    n_wa = tree_da; n_wb = tree_db;
                    rec_raddr = tree_da;
                end else if (r_sub == 2'd1) begin
                    rec_raddr = r_wb;
                end else begin
                    tree_we = 1'b1; tree_waddr = r_node; tree_wdata = win;
                    n_node = r_node >> 1;
                    if (r_state == tskt_pkg::S_BUILD_WR) n_node = r_node - TW'(1);
                end
                n_sub = r_sub + 2'd1;
            end
            tskt_pkg::S_ROOT_RD: tree_ra = TW'(1);
            tskt_pkg::S_ROOT_WR: begin
                scr_we = 1'b1; scr_waddr = r_j[AW-1:0]; scr_wdata = tree_da;
                cons_we = 1'b1; cons_waddr = tree_da; cons_wdata = 1'b1;
                n_j = r_j + CW'(1);
                n_node = (r_leaves + TW'(tree_da)) >> 1;
                if (r_j == r_count - CW'(1)) n_j = r_count;
            end
            tskt_pkg::S_PERM_RD: begin
                if (r_node == '0 && r_j == r_count) n_j = '0;
                scr_raddr = (r_j == r_count) ? '0 : r_j[AW-1:0];
                n_sub = '0;
            end
            tskt_pkg::S_PERM_WR: begin
                if (r_sub == 2'd0) begin
                    rec_raddr = scr_rdata;
                end else begin
                    tmp_wr = '{1'b1, rd_key, rec_rdata[PHW +: PLW], rec_rdata[PHW-1:0]};
                    tmp_waddr = r_j[AW-1:0];
                    n_j = r_j + CW'(1);
                    if (r_j == r_count - CW'(1)) n_j = '0;
                end
                n_sub = r_sub + 2'd1;
            end
            tskt_pkg::S_COPY_RD: tmp_raddr = r_j[AW-1:0];
            tskt_pkg::S_COPY_WR: begin
                rec_wr = '{1'b1, tmp_rdata[tskt_pkg::REC_W-1 -: KW],
                    tmp_rdata[PHW +: PLW], tmp_rdata[PHW-1:0]};
                rec_waddr = r_j[AW-1:0];
                n_j = r_j + CW'(1);
            end
            tskt_pkg::S_DONE: n_valid = 1'b1;
            default: ;
        endcase
        if (r_state == tskt_pkg::S_IDLE && start &&
            tskt_pkg::t_op'(i_opcode) != tskt_pkg::OP_SEARCH &&
            tskt_pkg::t_op'(i_opcode) != tskt_pkg::OP_SORT) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tskt_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tskt_pkg::S_IDLE && start) r_key <= i_key_value;
        if (r_state == tskt_pkg::S_SRCH_RD) r_mid <= mid_c[AW-1:0];
        if ((r_state == tskt_pkg::S_BUILD_WR || r_state == tskt_pkg::S_PATH_WR) &&
            r_sub == 2'd1) begin
            r_ka <= rd_key;
        end
        r_low <= n_low; r_high <= n_high; r_leaves <= n_leaves; r_node <= n_node;
        r_j <= n_j; r_wa <= n_wa; r_wb <= n_wb; r_sub <= n_sub;
        r_status <= n_status; r_fkey <= n_fkey; r_fplo <= n_fplo; r_fphi <= n_fphi;
    end

    assign busy = (r_state != tskt_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_found_key = r_fkey;
    assign o_found_payload_low = r_fplo;
    assign o_found_payload_high = r_fphi;
    assign o_record_count = 7'(r_count);

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES)) else $error("count overflow");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !busy) else $error("strobe while busy");
    a_found_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != tskt_pkg::ST_FOUND) |-> (r_fkey == '0))
        else $error("key on non-found result");
`endif
endmodule
